// ===== sv/pect_pkg.sv =====
// Package: sizes, types and the exact sign-agreement helper for the point-in-triangle test.
`timescale 1ns / 1ps
package pect_pkg;
  localparam int MaxVertices = 32;
  localparam int CoordBits   = 16;
  localparam int IdxBits     = $clog2(MaxVertices);
  localparam int CntBits     = $clog2(MaxVertices + 1);
  localparam int DiffBits    = CoordBits + 1;
  localparam int ProdBits    = 2 * DiffBits + 2;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic [CntBits-1:0]          count_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef struct packed {
    point_t a;
    point_t b;
    point_t c;
  } tri_t;

  typedef struct packed {
    logic   shift;
    logic   load;
    point_t load_pt;
    logic   rotate;
    logic   drop_head;
  } ring_ctl_t;

  function automatic logic agrees(input logic signed [ProdBits-1:0] v,
                                  input logic signed [ProdBits-1:0] d);
    agrees = (v == '0) || ((v > 0) == (d > 0));
  endfunction
endpackage

// ===== sv/pect_if.sv =====
// Interfaces: valid/ready channels for vertices and triangle results.
`timescale 1ns / 1ps
interface pect_vtx_if;
  import pect_pkg::*;
  logic   valid;
  logic   ready;
  coord_t vertex_x;
  coord_t vertex_y;
  logic   last_vertex;
  modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
  modport sink   (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

interface pect_tri_if;
  import pect_pkg::*;
  logic   valid;
  logic   ready;
  coord_t first_x;
  coord_t first_y;
  coord_t middle_x;
  coord_t middle_y;
  coord_t third_x;
  coord_t third_y;
  logic   triangle_valid;
  logic   last_triangle;
  logic   incomplete;
  logic   overflow;
  modport source (output valid, first_x, first_y, middle_x, middle_y, third_x, third_y,
                  triangle_valid, last_triangle, incomplete, overflow, input ready);
  modport sink   (input valid, first_x, first_y, middle_x, middle_y, third_x, third_y,
                  triangle_valid, last_triangle, incomplete, overflow, output ready);
endinterface

// ===== sv/pect_cell.sv =====
// One ring cell: holds one vertex and passes it to its neighbour when the ring moves.
`timescale 1ns / 1ps
module pect_cell import pect_pkg::*; (
  input  logic   clk,
  input  logic   move,
  input  point_t from_nb,
  output point_t pt
);
  always_ff @(posedge clk) begin
    if (move) pt <= from_nb;
  end
endmodule

// ===== sv/pect_ring.sv =====
// Vertex ring: a chain of cells that stores a loaded vertex at the tail and rotates during clipping.
`timescale 1ns / 1ps
module pect_ring import pect_pkg::*; (
  input  logic      clk,
  input  ring_ctl_t ctl,
  input  count_t    live,
  output point_t    cells [MaxVertices]
);
  point_t feed [MaxVertices];
  logic   move [MaxVertices];

  // Cell 0 is the head. Rotation moves cell i+1 into i within the live length,
  // head to the tail; dropping the head does the same but loses cell 0.
  always_comb begin
    for (int i = 0; i < MaxVertices; i++) begin
      move[i] = 1'b0;
      feed[i] = cells[i];
      if (ctl.load) begin
        move[i] = (i == MaxVertices - 1) ? (CntBits'(i) == live) : (CntBits'(i) == live);
        feed[i] = ctl.load_pt;
      end else if (ctl.rotate || ctl.drop_head) begin
        if (CntBits'(i) + 1'b1 < live) begin
          move[i] = 1'b1;
          feed[i] = cells[(i + 1) % MaxVertices];
        end else if (CntBits'(i) + 1'b1 == live) begin
          move[i] = ctl.rotate;
          feed[i] = cells[0];
        end
      end
    end
  end

  for (genvar g = 0; g < MaxVertices; g++) begin : g_cell
    pect_cell u_cell (.clk(clk), .move(move[g]), .from_nb(feed[g]), .pt(cells[g]));
  end
endmodule

// ===== sv/polygon_ear_clipping_triangulator_core.sv =====
// Top level: ear-clipping triangulator over a rotating ring of vertex cells.
// Loading: one vertex request per cycle; ready only in the load state, not while a polygon is being
// clipped or a result waits. Clipping: a turn test per candidate, inside tests against the other
// vertices for a clockwise candidate, then after each clip the restoring rotations and a restart.
// Results wait on tri_o.ready; a polygon of fewer than 3 gives its result in the cycle after the
// last vertex. Synchronous rst clears control; cells are not reset.
`timescale 1ns / 1ps
module polygon_ear_clipping_triangulator_core import pect_pkg::*; (
  input  logic clk,
  input  logic rst,
  pect_vtx_if.sink   vtx,
  pect_tri_if.source tri_o
);
  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_CAND  = 3'd1;
  localparam logic [2:0] S_TEST  = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_FINAL = 3'd4;
  localparam logic [2:0] S_WAIT  = 3'd5;

  localparam count_t FullCount  = count_t'(MaxVertices);
  localparam count_t TriCount   = count_t'(3);
  localparam count_t FirstProbe = count_t'(2);  // cells 0, 1 and the tail are the corners

  logic [2:0] state;
  count_t     held;        // live ring length
  count_t     held_after;  // length once the accepted vertex is stored
  logic       ovf;
  count_t     cand;        // candidates tried in this pass (= rotations from store order)
  count_t     scan;        // inside-test probe position, then rotations left to restore
  logic       out_valid;
  logic       res_tv;
  logic       res_last;
  logic       res_inc;
  tri_t       tri_r;

  point_t    cells [MaxVertices];
  ring_ctl_t ctl;

  // Candidate ear sits at the head: prev is the tail, next is cell 1.
  point_t pa, pb, pc, pp;
  logic signed [ProdBits-1:0] cr, dd, ss, tt;
  logic       in_tri;
  logic [IdxBits-1:0] tail_idx, probe_idx;

  assign tail_idx  = IdxBits'(held - 1'b1);
  assign probe_idx = IdxBits'(scan);
  assign pa = cells[tail_idx];
  assign pb = cells[0];
  assign pc = cells[1];
  assign pp = cells[probe_idx];

  // Turn and D are the same product; products are narrow enough (17x17).
  always_comb begin
    dd = ProdBits'((DiffBits'(pb.x) - DiffBits'(pa.x)) * (DiffBits'(pc.y) - DiffBits'(pa.y)))
       - ProdBits'((DiffBits'(pb.y) - DiffBits'(pa.y)) * (DiffBits'(pc.x) - DiffBits'(pa.x)));
    cr = dd;
    ss = ProdBits'(pa.y * pc.x) - ProdBits'(pa.x * pc.y)
       + ProdBits'((DiffBits'(pc.y) - DiffBits'(pa.y)) * pp.x)
       + ProdBits'((DiffBits'(pa.x) - DiffBits'(pc.x)) * pp.y);
    tt = ProdBits'(pa.x * pb.y) - ProdBits'(pa.y * pb.x)
       + ProdBits'((DiffBits'(pa.y) - DiffBits'(pb.y)) * pp.x)
       + ProdBits'((DiffBits'(pb.x) - DiffBits'(pa.x)) * pp.y);
    in_tri = (dd != '0) && agrees(ss, dd) && agrees(tt, dd) && agrees(dd - ss - tt, dd);
  end

  logic accept;
  assign vtx.ready  = (state == S_LOAD);
  assign accept     = vtx.valid && vtx.ready;
  assign held_after = (held < FullCount) ? held + 1'b1 : held;

  // Ring moves: rotate to the next candidate on a reject, drop the head when the
  // ear request is taken, then rotate back until the first stored vertex still held leads.
  always_comb begin
    ctl = '0;
    ctl.load_pt = '{x: vtx.vertex_x, y: vtx.vertex_y};
    ctl.load = accept && (held < FullCount);
    case (state)
      S_CAND:  ctl.rotate = (held != TriCount) && (cr >= 0) && (cand + 1'b1 < held);
      S_TEST:  ctl.rotate = in_tri && (cand + 1'b1 < held);
      S_EMIT:  ctl.drop_head = tri_o.ready;
      S_FINAL: ctl.rotate = (scan != '0);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD; held <= '0; ovf <= 1'b0; out_valid <= 1'b0;
      cand <= '0; scan <= '0;
      res_tv <= 1'b0; res_last <= 1'b0; res_inc <= 1'b0;
    end else begin
      case (state)
        S_LOAD: if (accept) begin
          if (held < FullCount) held <= held + 1'b1;
          else ovf <= 1'b1;
          if (vtx.last_vertex) begin
            if (held_after < TriCount) begin
              // too few vertices: a single empty closing result
              tri_r <= '0; res_tv <= 1'b0; res_last <= 1'b1; res_inc <= 1'b0;
              out_valid <= 1'b1; state <= S_WAIT;
            end else begin
              cand <= '0; state <= S_CAND;
            end
          end
        end
        S_CAND: if (held == TriCount) begin
          // three left, ring is in store order
          tri_r <= '{a: cells[0], b: cells[1], c: cells[2]};
          res_tv <= 1'b1; res_last <= 1'b1; res_inc <= 1'b0;
          out_valid <= 1'b1; state <= S_WAIT;
        end else if (cr < 0) begin
          scan <= FirstProbe; state <= S_TEST;
        end else if (cand + 1'b1 < held) begin
          cand <= cand + 1'b1;
        end else begin
          // no ear anywhere: closing incomplete marker
          tri_r <= '0; res_tv <= 1'b0; res_last <= 1'b1; res_inc <= 1'b1;
          out_valid <= 1'b1; state <= S_WAIT;
        end
        S_TEST: if (in_tri) begin
          if (cand + 1'b1 < held) begin
            cand <= cand + 1'b1; state <= S_CAND;
          end else begin
            tri_r <= '0; res_tv <= 1'b0; res_last <= 1'b1; res_inc <= 1'b1;
            out_valid <= 1'b1; state <= S_WAIT;
          end
        end else if (scan + 1'b1 >= held - 1'b1) begin
          tri_r <= '{a: pa, b: pb, c: pc};
          res_tv <= 1'b1; res_last <= 1'b0; res_inc <= 1'b0;
          out_valid <= 1'b1; state <= S_EMIT;
        end else scan <= scan + 1'b1;
        S_EMIT: if (tri_o.ready) begin
          // head dropped; unless it was the head, old vertex 0 now sits at held-1-cand of the shorter ring
          out_valid <= 1'b0;
          held <= held - 1'b1;
          scan <= (cand == '0) ? '0 : held - 1'b1 - cand;
          state <= S_FINAL;
        end
        S_FINAL: begin
          if (scan != '0) scan <= scan - 1'b1;
          else begin cand <= '0; state <= S_CAND; end
        end
        S_WAIT: if (tri_o.ready) begin
          out_valid <= 1'b0; held <= '0; ovf <= 1'b0;
          state <= S_LOAD;
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  assign tri_o.valid          = out_valid;
  assign tri_o.first_x        = tri_r.a.x;
  assign tri_o.first_y        = tri_r.a.y;
  assign tri_o.middle_x       = tri_r.b.x;
  assign tri_o.middle_y       = tri_r.b.y;
  assign tri_o.third_x        = tri_r.c.x;
  assign tri_o.third_y        = tri_r.c.y;
  assign tri_o.triangle_valid = res_tv;
  assign tri_o.last_triangle  = res_last;
  assign tri_o.incomplete     = res_inc;
  assign tri_o.overflow       = ovf;

  pect_ring u_ring (.clk(clk), .ctl(ctl), .live(held), .cells(cells));
endmodule

// ===== sv/pect_checker.sv =====
// Checker: port-level properties of the triangulator, bound to the top level.
`timescale 1ns / 1ps
module pect_checker import pect_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic triangle_valid,
  input logic last_triangle,
  input logic incomplete
);
  a_no_accept_while_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("vertex taken while result pending");
  a_incomplete_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && incomplete |-> last_triangle && !triangle_valid)
    else $error("incomplete marker malformed");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
endmodule

bind polygon_ear_clipping_triangulator_core pect_checker u_chk (
  .clk(clk), .rst(rst), .in_ready(vtx.ready),
  .out_valid(tri_o.valid), .out_ready(tri_o.ready),
  .triangle_valid(tri_o.triangle_valid), .last_triangle(tri_o.last_triangle),
  .incomplete(tri_o.incomplete)
);
